>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ACC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ACC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/acc_pkg.sv
// Package for the ADC channel code converter: widths, constant tables,
// queue item and configuration types. No dependencies.
`default_nettype none

package acc_pkg;

    localparam int NUM_CHANNELS_DEF  = 16;
    localparam int THERM_ENTRIES_DEF = 59;

    localparam int CH_W     = 4;
    localparam int CODE_W   = 10;
    localparam int VAL_W    = 17;
    localparam int QTY_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int MUL_W    = 19;
    localparam int PROD_W   = CODE_W + MUL_W;
    localparam int DVD_W    = 36;
    localparam int DVS_W    = 16;
    localparam int VOLT_W   = 26;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    localparam int TBL_SLOTS = 64;
    localparam int TBL_IDX_W = $clog2(TBL_SLOTS);
    localparam int SRCH_W    = TBL_IDX_W + 1;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [CH_W-1:0]   CH_TEMP = 4'd1;
    localparam logic [CH_W-1:0]   CH_CURR = 4'd10;

    localparam logic [QTY_W-1:0]  QTY_MV   = 2'd0;
    localparam logic [QTY_W-1:0]  QTY_TEMP = 2'd1;
    localparam logic [QTY_W-1:0]  QTY_CURR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_DIV  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURR_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CURR_DIVH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CURR_DIVL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd6;

    localparam logic [VAL_W-1:0]  VAL_MAX      = 17'h0FFFF;
    localparam int                CURR_OFFSET  = 750;
    localparam logic [DVD_W-1:0]  CURR_LIMIT   = DVD_W'(65535 + CURR_OFFSET);
    localparam logic [VAL_W-1:0]  TEMP_SHIFT   = 17'd3;
    localparam logic [9:0]        RES_SCALE    = 10'd1000;

    typedef enum logic [1:0] {
        K_VOLT = 2'd0,
        K_TEMP = 2'd1,
        K_CURR = 2'd2,
        K_OOR  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [DVD_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } t_item;

    typedef struct packed {
        logic [15:0] temp_step;
        logic [15:0] temp_div;
        logic [11:0] bias;
        logic [15:0] curr_step;
        logic [15:0] curr_div_hi;
        logic [15:0] curr_div_lo;
        logic        gain;
    } t_cfg;

    // 3000 * den per channel
    localparam logic [MUL_W-1:0] VOLT_MUL [16] = '{
        19'd3000,  19'd3000,  19'd30000, 19'd30000, 19'd30000, 19'd30000,
        19'd30000, 19'd30000, 19'd42000, 19'd9000,  19'd3000,  19'd300000,
        19'd12000, 19'd3000,  19'd3000,  19'd33000
    };

    // 2046 * num per channel
    localparam logic [DVS_W-1:0] VOLT_DIV [16] = '{
        16'd2046,  16'd2046,  16'd12276, 16'd12276, 16'd12276, 16'd12276,
        16'd12276, 16'd12276, 16'd6138,  16'd2046,  16'd2046,  16'd30690,
        16'd2046,  16'd2046,  16'd2046,  16'd10230
    };

    // Thermistor resistance, high to low
    localparam logic [15:0] THERM_RES [TBL_SLOTS] = '{
        16'd30800, 16'd29500, 16'd28300, 16'd27100, 16'd26000, 16'd24900,
        16'd23900, 16'd22900, 16'd22000, 16'd21100, 16'd20300, 16'd19400,
        16'd18700, 16'd17900, 16'd17200, 16'd16500, 16'd15900, 16'd15300,
        16'd14700, 16'd14100, 16'd13600, 16'd13100, 16'd12600, 16'd12100,
        16'd11600, 16'd11200, 16'd10800, 16'd10400, 16'd10000, 16'd9630,
        16'd9280,  16'd8950,  16'd8620,  16'd8310,  16'd8020,  16'd7730,
        16'd7460,  16'd7200,  16'd6950,  16'd6710,  16'd6470,  16'd6250,
        16'd6040,  16'd5830,  16'd5640,  16'd5450,  16'd5260,  16'd5090,
        16'd4920,  16'd4760,  16'd4600,  16'd4450,  16'd4310,  16'd4170,
        16'd4040,  16'd3910,  16'd3790,  16'd3670,  16'd3550,  16'd3550,
        16'd3550,  16'd3550,  16'd3550,  16'd3550
    };

    // Zero divisor acts as one.
    function automatic logic [DVS_W-1:0] nz(input logic [DVS_W-1:0] d);
        nz = (d == '0) ? DVS_W'(1) : d;
    endfunction

endpackage

`default_nettype wire

>>> sv/acc_front.sv
// Front end: takes start commands, classifies the channel and forms the
// dividend and divisor for the queue. Depends on acc_pkg.
`default_nettype none

module acc_front
    import acc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic              start,
    input  wire logic [CH_W-1:0]   i_channel,
    input  wire logic [CODE_W-1:0] i_raw_code,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_full,
    output logic                   o_push,
    output t_item                  o_item
);

    logic [MUL_W-1:0]  mul_op;
    logic [DVS_W-1:0]  divisor;
    logic [PROD_W-1:0] prod;
    t_kind             kind;

    always_comb begin
        if ({1'b0, i_channel} >= (CH_W+1)'(NUM_CHANNELS)) begin
            kind = K_OOR;
        end else if (i_channel == CH_CURR) begin
            kind = K_CURR;
        end else if (i_channel == CH_TEMP) begin
            kind = K_TEMP;
        end else begin
            kind = K_VOLT;
        end
    end

    always_comb begin
        unique case (kind)
            K_CURR: begin
                mul_op  = MUL_W'(i_cfg.curr_step);
                divisor = nz(i_cfg.gain ? i_cfg.curr_div_hi : i_cfg.curr_div_lo);
            end
            K_TEMP: begin
                mul_op  = MUL_W'(i_cfg.temp_step);
                divisor = nz(i_cfg.temp_div);
            end
            K_VOLT: begin
                mul_op  = VOLT_MUL[i_channel];
                divisor = VOLT_DIV[i_channel];
            end
            default: begin
                mul_op  = '0;
                divisor = DVS_W'(1);
            end
        endcase
    end

    assign prod   = PROD_W'(i_raw_code) * PROD_W'(mul_op);
    assign o_item = {kind, DVD_W'(prod), divisor};
    assign o_push = start && !i_full;

endmodule

`default_nettype wire

>>> sv/acc_fifo.sv
// Short item queue between front and back end.
// Depends on acc_pkg.
`default_nettype none

module acc_fifo
    import acc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_item      o_head,
    output logic       o_full,
    output logic       o_empty
);

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_CW-1:0] r_count;
    logic [FIFO_CW-1:0] n_count;

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> sv/acc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on acc_pkg.
`default_nettype none

module acc_div
    import acc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DVD_W-1:0]      o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [DVD_W-1:0]     r_quo;
    logic [DVS_W:0]       trial;
    logic                 fits;

    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> sv/acc_back.sv
// Back end: sequences the shared divider, the resistance scaling and the
// thermistor table search, then clamps and strobes the result. Depends on acc_pkg, acc_div.
`default_nettype none

module acc_back
    import acc_pkg::*;
#(
    parameter int THERM_ENTRIES = THERM_ENTRIES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_item             i_head,
    input  wire logic              i_empty,
    input  wire t_cfg              i_cfg,
    output logic                   o_pop,
    output logic                   o_result_valid,
    output logic signed [VAL_W-1:0] o_value,
    output logic [QTY_W-1:0]       o_quantity
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV1   = 6'b000010,
        S_SCALE  = 6'b000100,
        S_DIV2   = 6'b001000,
        S_SEARCH = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    t_kind               r_kind;
    logic [DVD_W-1:0]    r_dvd;
    logic [DVD_W-1:0]    r_res;
    logic [SRCH_W-1:0]   r_lo;
    logic [SRCH_W-1:0]   r_hi;
    logic [VAL_W-1:0]    r_val;
    logic [QTY_W-1:0]    r_qty;

    logic                div_start;
    logic [DVD_W-1:0]    div_dvd;
    logic [DVS_W-1:0]    div_dvs;
    logic                div_done;
    logic [DVD_W-1:0]    quo;
    logic [DVD_W-1:0]    scaled;
    logic [SRCH_W:0]     mid_sum;
    logic [SRCH_W-1:0]   mid;
    logic                hit;
    logic [VAL_W:0]      curr_diff;

    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign div_start = (o_pop && (i_head.kind != K_OOR)) || (r_state == S_SCALE);
    assign div_dvd   = (r_state == S_IDLE) ? i_head.dividend : r_dvd;
    assign div_dvs   = (r_state == S_IDLE) ? i_head.divisor : nz(DVS_W'(i_cfg.bias));

    acc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    assign scaled    = DVD_W'(quo[VOLT_W-1:0]) * DVD_W'(RES_SCALE);
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = mid_sum[SRCH_W:1];
    assign hit       = ({{(DVD_W-16){1'b0}}, THERM_RES[mid[TBL_IDX_W-1:0]]} >= r_res);
    assign curr_diff = (VAL_W+1)'(quo[VAL_W-1:0]) - (VAL_W+1)'(CURR_OFFSET);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_head.kind == K_OOR) ? S_OUT : S_DIV1;
                end
            end
            S_DIV1: begin
                if (div_done) begin
                    n_state = (r_kind == K_TEMP) ? S_SCALE : S_OUT;
                end
            end
            S_SCALE:  n_state = S_DIV2;
            S_DIV2: begin
                if (div_done) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_lo >= r_hi) begin
                    n_state = S_OUT;
                end
            end
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_kind <= i_head.kind;
                r_val  <= '0;
                r_qty  <= QTY_MV;
            end
            S_DIV1: begin
                if (div_done) begin
                    unique case (r_kind)
                        K_CURR: begin
                            r_qty <= QTY_CURR;
                            r_val <= (quo > CURR_LIMIT) ? VAL_MAX : curr_diff[VAL_W-1:0];
                        end
                        K_TEMP: begin
                            r_qty <= QTY_TEMP;
                            r_dvd <= scaled;
                        end
                        default: begin
                            r_qty <= QTY_MV;
                            r_val <= (|quo[DVD_W-1:VAL_W-1]) ? VAL_MAX
                                                             : VAL_W'(quo[VAL_W-2:0]);
                        end
                    endcase
                end
            end
            S_DIV2: begin
                r_res <= quo;
                r_lo  <= '0;
                r_hi  <= SRCH_W'(THERM_ENTRIES);
            end
            S_SEARCH: begin
                if (r_lo < r_hi) begin
                    if (hit) begin
                        r_lo <= mid + 1'b1;
                    end else begin
                        r_hi <= mid;
                    end
                end else begin
                    r_val <= VAL_W'(r_lo) - TEMP_SHIFT;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result_valid = (r_state == S_OUT);
    assign o_value        = r_val;
    assign o_quantity     = r_qty;

endmodule

`default_nettype wire

>>> sv/adc_channel_code_converter.sv
// Top level of the ADC channel code converter: configuration registers,
// front end, item queue and back end. Depends on acc_pkg, acc_front, acc_fifo, acc_back.
//
// An item is taken on start while busy is low and yields one result, shown
// for exactly one cycle with o_result_valid; the receiver cannot stall it.
// A two-entry queue holds accepted items, so start may be given while an
// earlier item is still being worked; busy is high only while the queue is
// full. The back end shares one 36-step restoring divider: a channel beyond
// the channel count skips it, current and voltage channels use one division,
// the temperature channel two with a resistance scaling between, then a binary
// table search (at most 7 steps). Configuration registers are written through
// the cfg channel, which is always ready; write them only while idle.

`default_nettype none

module adc_channel_code_converter
    import acc_pkg::*;
#(
    parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF,
    parameter int THERM_ENTRIES = THERM_ENTRIES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire logic [CH_W-1:0]      i_channel,
    input  wire logic [CODE_W-1:0]    i_raw_code,
    output logic                      busy,
    output logic                      o_result_valid,
    output logic signed [VAL_W-1:0]   o_value,
    output logic [QTY_W-1:0]          o_quantity,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_item push_item;
    t_item head;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_step   <= 16'd1;
            r_cfg.temp_div    <= 16'd1;
            r_cfg.bias        <= 12'd1;
            r_cfg.curr_step   <= 16'd1;
            r_cfg.curr_div_hi <= 16'd1;
            r_cfg.curr_div_lo <= 16'd1;
            r_cfg.gain        <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TEMP_STEP: r_cfg.temp_step   <= i_cfg_data;
                CFG_TEMP_DIV:  r_cfg.temp_div    <= i_cfg_data;
                CFG_BIAS:      r_cfg.bias        <= i_cfg_data[11:0];
                CFG_CURR_STEP: r_cfg.curr_step   <= i_cfg_data;
                CFG_CURR_DIVH: r_cfg.curr_div_hi <= i_cfg_data;
                CFG_CURR_DIVL: r_cfg.curr_div_lo <= i_cfg_data;
                CFG_GAIN:      r_cfg.gain        <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    acc_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .start      (start),
        .i_channel  (i_channel),
        .i_raw_code (i_raw_code),
        .i_cfg      (r_cfg),
        .i_full     (full),
        .o_push     (push),
        .o_item     (push_item)
    );

    acc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    acc_back #(
        .THERM_ENTRIES (THERM_ENTRIES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_empty        (empty),
        .i_cfg          (r_cfg),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_value        (o_value),
        .o_quantity     (o_quantity)
    );

    assign busy = full;

endmodule

`default_nettype wire

>>> sv/acc_checker.sv
// Port-level checker for the ADC channel code converter, bound to the top.
// Depends on acc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module acc_checker
    import acc_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire logic                   o_result_valid,
    input wire logic signed [VAL_W-1:0] o_value,
    input wire logic [QTY_W-1:0]       o_quantity
);

    logic qty_legal;
    logic temp_beat;
    logic temp_ok;
    logic curr_beat;
    logic quiet_in;

    assign qty_legal = (o_quantity == QTY_MV) || (o_quantity == QTY_TEMP)
                    || (o_quantity == QTY_CURR);
    assign temp_beat = o_result_valid && (o_quantity == QTY_TEMP);
    assign temp_ok   = (o_value >= -17'sd3) && (o_value <= 17'sd61);
    assign curr_beat = o_result_valid && (o_quantity == QTY_CURR);
    assign quiet_in  = !start && !busy;

    `ACC_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_result_valid, !o_result_valid, "strobe held")
    `ACC_ASSERT(a_qty_code, i_clk, i_rst_n, (o_result_valid |-> qty_legal), "illegal quantity")
    `ACC_ASSERT(a_temp_range, i_clk, i_rst_n, (temp_beat |-> temp_ok), "temperature out of range")
    `ACC_ASSERT(a_curr_floor, i_clk, i_rst_n, (curr_beat |-> (o_value >= -17'sd750)), "current low")
    `ACC_ASSERT_NEXT(a_busy_rise, i_clk, i_rst_n, quiet_in, !busy, "busy without accepted beat")

endmodule

bind adc_channel_code_converter acc_checker u_acc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_value        (o_value),
    .o_quantity     (o_quantity)
);

`default_nettype wire
